/* rtl/core/hmt_pkg.sv */
// Shared codes for the heartbeat membership table.
package hmt_pkg;

    typedef enum logic [1:0] {
        OP_OBSERVE = 2'd0,
        OP_LEAVE   = 2'd1,
        OP_SWEEP   = 2'd2,
        OP_QUERY   = 2'd3
    } opcode_t;

    typedef enum logic [3:0] {
        ST_ACCEPTED  = 4'd0,
        ST_DUPLICATE = 4'd1,
        ST_STALE_INC = 4'd2,
        ST_STALE_SEQ = 4'd3,
        ST_INVALID   = 4'd4,
        ST_FULL      = 4'd5,
        ST_LEFT      = 4'd6,
        ST_REFUSED   = 4'd7,
        ST_DONE      = 4'd8
    } status_t;

    typedef enum logic [1:0] {
        CFG_TTL       = 2'd0,
        CFG_RETENTION = 2'd1,
        CFG_LIMIT     = 2'd2
    } cfg_index_t;

    typedef enum logic [1:0] {
        FSM_IDLE  = 2'd0,
        FSM_SCAN  = 2'd1,
        FSM_APPLY = 2'd2
    } fsm_t;

    localparam int KEY_W  = 64;
    localparam int TTL_W  = 22;
    localparam int RET_W  = 27;
    localparam int DROP_W = 28;
    localparam int LIM_W  = 7;
    localparam int CNT_W  = 7;

endpackage

/* rtl/core/hmt_cell.sv */
// One table slot: ages itself and folds its entry into the passing scan token.
module hmt_cell #(
    parameter int IDX = 0,
    parameter int IW  = 6,
    parameter int TW  = 48,
    parameter int CW  = 7,
    parameter int GW  = 8,
    parameter int TOK_W = 1 + GW + 1 + IW + 64 + 64 + 1 + 3 * CW + 1 + IW + 1 + IW + TW + 64
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic [TOK_W-1:0]          tok_in,
    output logic [TOK_W-1:0]          tok_out,
    input  logic                      age_en,
    input  logic [hmt_pkg::KEY_W-1:0] op_key,
    input  logic [63:0]               op_inc,
    input  logic [63:0]               op_seq,
    input  logic [TW-1:0]             now,
    input  logic [hmt_pkg::TTL_W-1:0] ttl,
    input  logic [hmt_pkg::DROP_W-1:0] drop,
    input  logic                      wr_en,
    input  logic [IW-1:0]             wr_idx,
    input  logic [TW-1:0]             wr_seen,
    input  logic                      wr_exp,
    input  logic                      clr_en,
    input  logic [IW-1:0]             clr_idx
);

    typedef struct packed {
        logic                      valid;
        logic [GW-1:0]             gdelta;
        logic                      found;
        logic [IW-1:0]             fidx;
        logic [63:0]               finc;
        logic [63:0]               fseq;
        logic                      fexp;
        logic [CW-1:0]             used_cnt;
        logic [CW-1:0]             alive;
        logic [CW-1:0]             expc;
        logic                      free_ok;
        logic [IW-1:0]             free_idx;
        logic                      ev_ok;
        logic [IW-1:0]             ev_idx;
        logic [TW-1:0]             ev_seen;
        logic [hmt_pkg::KEY_W-1:0] ev_key;
    } tok_t;

    localparam logic [IW-1:0] MY_IDX = IW'(IDX);

    tok_t tin;
    tok_t tnext;
    tok_t tout_reg;

    logic                      used_reg;
    logic                      exp_reg;
    logic [hmt_pkg::KEY_W-1:0] key_reg;
    logic [63:0]               inc_reg;
    logic [63:0]               seq_reg;
    logic [TW-1:0]             seen_reg;

    logic [TW-1:0] age;
    logic          mark_exp;
    logic          rm;
    logic          exp1;
    logic          used1;
    logic          better;

    assign tin     = tok_in;
    assign tok_out = tout_reg;

    always_comb
    begin
        age      = (now > seen_reg) ? now - seen_reg : '0;
        mark_exp = used_reg && age_en && !exp_reg && (age >= TW'(ttl));
        exp1     = exp_reg || mark_exp;
        rm       = used_reg && age_en && exp1 && (age >= TW'(drop));
        used1    = used_reg && !rm;
        better   = !tin.ev_ok || (seen_reg < tin.ev_seen) ||
                   ((seen_reg == tin.ev_seen) && (key_reg < tin.ev_key));

        tnext          = tin;
        tnext.gdelta   = tin.gdelta + GW'(mark_exp) + GW'(rm);
        tnext.used_cnt = tin.used_cnt + CW'(used1);
        tnext.alive    = tin.alive + CW'(used1 && !exp1);
        tnext.expc     = tin.expc + CW'(used1 && exp1);
        if (used1 && !tin.found && (key_reg == op_key))
        begin
            tnext.found = 1'b1;
            tnext.fidx  = MY_IDX;
            tnext.finc  = inc_reg;
            tnext.fseq  = seq_reg;
            tnext.fexp  = exp1;
        end
        if (!used1 && !tin.free_ok)
        begin
            tnext.free_ok  = 1'b1;
            tnext.free_idx = MY_IDX;
        end
        if (used1 && exp1 && better)
        begin
            tnext.ev_ok   = 1'b1;
            tnext.ev_idx  = MY_IDX;
            tnext.ev_seen = seen_reg;
            tnext.ev_key  = key_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tout_reg <= '0;
            used_reg <= 1'b0;
        end
        else
        begin
            tout_reg <= tnext;
            // an evicted slot that is refilled in the same cycle stays in use
            if (wr_en && (wr_idx == MY_IDX))
                used_reg <= 1'b1;
            else if (clr_en && (clr_idx == MY_IDX))
                used_reg <= 1'b0;
            else if (tin.valid)
                used_reg <= used1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en && (wr_idx == MY_IDX))
        begin
            exp_reg  <= wr_exp;
            key_reg  <= op_key;
            inc_reg  <= op_inc;
            seq_reg  <= op_seq;
            seen_reg <= wr_seen;
        end
        else if (tin.valid)
            exp_reg <= exp1;
    end

endmodule

/* rtl/core/heartbeat_membership_table_core.sv */
// Heartbeat membership table: slot chain, scan control and result register.
// The scan token walks the slot chain one cell a cycle; the result register
// captures it and the apply state then applies the update, which waits while an
// earlier result beat is still held. No new operation is taken until the apply
// state has committed its result and the core is back in idle.
// Reset clears all slots to unused, generation to zero and config to defaults;
// the table is ready to accept an operation as soon as reset is released.
module heartbeat_membership_table_core #(
    parameter int CAPACITY  = 64,
    parameter int TIME_BITS = 48
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // member_id[63:0], incarnation[127:64], sequence_req[191:128], time_ms[239:192]
    input  logic [239:0] s_axis_tdata,
    // opcode[1:0], text_ok[2]
    input  logic [2:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // status[3:0], changed[4], generation[68:5], alive_count[75:69],
    // expired_count[82:76], zero[87:83]
    output logic [87:0]  m_axis_tdata,
    input  logic         cfg_we,
    input  logic [1:0]   cfg_index,
    input  logic [26:0]  cfg_data
);

    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int TW = TIME_BITS;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int GW = $clog2(2 * CAPACITY + 1);
    localparam int TOK_W = 1 + GW + 1 + IW + 64 + 64 + 1 + 3 * CW + 1 + IW + 1 + IW + TW + 64;

    typedef struct packed {
        logic                      valid;
        logic [GW-1:0]             gdelta;
        logic                      found;
        logic [IW-1:0]             fidx;
        logic [63:0]               finc;
        logic [63:0]               fseq;
        logic                      fexp;
        logic [CW-1:0]             used_cnt;
        logic [CW-1:0]             alive;
        logic [CW-1:0]             expc;
        logic                      free_ok;
        logic [IW-1:0]             free_idx;
        logic                      ev_ok;
        logic [IW-1:0]             ev_idx;
        logic [TW-1:0]             ev_seen;
        logic [hmt_pkg::KEY_W-1:0] ev_key;
    } tok_t;

    // configuration
    logic [hmt_pkg::TTL_W-1:0] ttl_reg;
    logic [hmt_pkg::RET_W-1:0] ret_reg;
    logic [hmt_pkg::LIM_W-1:0] limit_reg;
    logic [hmt_pkg::DROP_W-1:0] drop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ttl_reg   <= hmt_pkg::TTL_W'(5000);
            ret_reg   <= hmt_pkg::RET_W'(10000);
            limit_reg <= hmt_pkg::LIM_W'(64);
        end
        else if (cfg_we)
        begin
            case (hmt_pkg::cfg_index_t'(cfg_index))
                hmt_pkg::CFG_TTL:       ttl_reg   <= cfg_data[hmt_pkg::TTL_W-1:0];
                hmt_pkg::CFG_RETENTION: ret_reg   <= cfg_data;
                hmt_pkg::CFG_LIMIT:     limit_reg <= cfg_data[hmt_pkg::LIM_W-1:0];
                default: ;
            endcase
        end
    end

    assign drop = hmt_pkg::DROP_W'(ttl_reg) + hmt_pkg::DROP_W'(ret_reg);

    // operation registers
    hmt_pkg::opcode_t op_reg;
    logic             text_ok_reg;
    logic [63:0]      key_reg;
    logic [63:0]      inc_reg;
    logic [63:0]      seq_reg;
    logic [TW-1:0]    now_reg;
    logic [63:0]      time64;
    logic             invalid_obs;
    logic             age_en;

    assign time64      = {16'd0, s_axis_tdata[239:192]};
    assign invalid_obs = (op_reg == hmt_pkg::OP_OBSERVE) &&
                         (!text_ok_reg || (inc_reg == '0) || (seq_reg == '0));
    assign age_en      = !invalid_obs;

    hmt_pkg::fsm_t state_reg;
    hmt_pkg::fsm_t state_next;
    logic          accept;
    logic          start_reg;
    logic          out_free;
    logic          commit;
    tok_t          res_reg;
    tok_t          start_tok;
    tok_t          end_tok;

    logic [TOK_W-1:0] link [CAPACITY+1];

    assign accept   = s_axis_tvalid && s_axis_tready;
    assign out_free = !m_axis_tvalid || m_axis_tready;

    always_comb
    begin
        start_tok       = '0;
        start_tok.valid = start_reg;
    end

    assign link[0] = start_tok;
    assign end_tok = link[CAPACITY];

    // write command produced in the apply cycle
    logic          wr_en;
    logic [IW-1:0] wr_idx;
    logic [TW-1:0] wr_seen;
    logic          wr_exp;
    logic          clr_en;

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            hmt_cell #(
                .IDX (gi),
                .IW  (IW),
                .TW  (TW),
                .CW  (CW),
                .GW  (GW)
            ) u_cell (
                .clk     (clk),
                .rst_n   (rst_n),
                .tok_in  (link[gi]),
                .tok_out (link[gi+1]),
                .age_en  (age_en),
                .op_key  (key_reg),
                .op_inc  (inc_reg),
                .op_seq  (seq_reg),
                .now     (now_reg),
                .ttl     (ttl_reg),
                .drop    (drop),
                .wr_en   (wr_en && commit),
                .wr_idx  (wr_idx),
                .wr_seen (wr_seen),
                .wr_exp  (wr_exp),
                .clr_en  (clr_en && commit),
                .clr_idx (res_reg.ev_idx)
            );
        end
    endgenerate

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            hmt_pkg::FSM_IDLE:  if (accept) state_next = hmt_pkg::FSM_SCAN;
            hmt_pkg::FSM_SCAN:  if (end_tok.valid) state_next = hmt_pkg::FSM_APPLY;
            hmt_pkg::FSM_APPLY: if (out_free) state_next = hmt_pkg::FSM_IDLE;
            default:            state_next = hmt_pkg::FSM_IDLE;
        endcase
    end

    // outputs of the state machine
    always_comb
    begin
        s_axis_tready = 1'b0;
        commit        = 1'b0;
        case (state_reg)
            hmt_pkg::FSM_IDLE:  s_axis_tready = 1'b1;
            hmt_pkg::FSM_APPLY: commit = out_free;
            default: ;
        endcase
    end

    // decision on the finished scan
    hmt_pkg::status_t status;
    logic             changed;
    logic [1:0]       gen_extra;
    logic [CW-1:0]    alive_n;
    logic [CW-1:0]    expc_n;
    logic [31:0]      lim32;
    logic             need_ev;
    logic [TW-1:0]    leave_seen;
    logic [TW-1:0]    ttl_t;

    assign ttl_t      = TW'(ttl_reg);
    assign leave_seen = (now_reg > ttl_t) ? now_reg - ttl_t : '0;
    assign lim32      = (32'(limit_reg) > 32'(CAPACITY)) ? 32'(CAPACITY) : 32'(limit_reg);
    assign need_ev    = 32'(res_reg.used_cnt) >= lim32;

    always_comb
    begin
        status    = hmt_pkg::ST_DONE;
        changed   = 1'b0;
        gen_extra = 2'd0;
        alive_n   = res_reg.alive;
        expc_n    = res_reg.expc;
        wr_en     = 1'b0;
        wr_idx    = res_reg.fidx;
        wr_seen   = now_reg;
        wr_exp    = 1'b0;
        clr_en    = 1'b0;
        case (op_reg)
            hmt_pkg::OP_OBSERVE:
            begin
                if (invalid_obs)
                    status = hmt_pkg::ST_INVALID;
                else if (res_reg.found)
                begin
                    if (inc_reg < res_reg.finc)
                        status = hmt_pkg::ST_STALE_INC;
                    else if ((inc_reg == res_reg.finc) && (seq_reg < res_reg.fseq))
                        status = hmt_pkg::ST_STALE_SEQ;
                    else if ((inc_reg == res_reg.finc) && (seq_reg == res_reg.fseq))
                        status = hmt_pkg::ST_DUPLICATE;
                    else
                    begin
                        status    = hmt_pkg::ST_ACCEPTED;
                        changed   = 1'b1;
                        gen_extra = 2'd1;
                        wr_en     = 1'b1;
                        if (res_reg.fexp)
                        begin
                            alive_n = res_reg.alive + CW'(1);
                            expc_n  = res_reg.expc - CW'(1);
                        end
                    end
                end
                else if (need_ev && !res_reg.ev_ok)
                    status = hmt_pkg::ST_FULL;
                else if (need_ev)
                begin
                    // evict the oldest expired entry, then write the lower of the lowest free slot and the evicted slot
                    status    = hmt_pkg::ST_ACCEPTED;
                    changed   = 1'b1;
                    gen_extra = 2'd2;
                    clr_en    = 1'b1;
                    wr_en     = 1'b1;
                    wr_idx    = (res_reg.free_ok && (res_reg.free_idx < res_reg.ev_idx)) ?
                                res_reg.free_idx : res_reg.ev_idx;
                    alive_n   = res_reg.alive + CW'(1);
                    expc_n    = res_reg.expc - CW'(1);
                end
                else if (!res_reg.free_ok)
                    status = hmt_pkg::ST_FULL;
                else
                begin
                    status    = hmt_pkg::ST_ACCEPTED;
                    changed   = 1'b1;
                    gen_extra = 2'd1;
                    wr_en     = 1'b1;
                    wr_idx    = res_reg.free_idx;
                    alive_n   = res_reg.alive + CW'(1);
                end
            end
            hmt_pkg::OP_LEAVE:
            begin
                if (res_reg.found && (inc_reg == res_reg.finc) && (seq_reg > res_reg.fseq))
                begin
                    status    = hmt_pkg::ST_LEFT;
                    changed   = 1'b1;
                    gen_extra = 2'd1;
                    wr_en     = 1'b1;
                    wr_seen   = leave_seen;
                    wr_exp    = 1'b1;
                    if (!res_reg.fexp)
                    begin
                        alive_n = res_reg.alive - CW'(1);
                        expc_n  = res_reg.expc + CW'(1);
                    end
                end
                else
                    status = hmt_pkg::ST_REFUSED;
            end
            default: status = hmt_pkg::ST_DONE;
        endcase
    end

    // control registers
    logic [63:0] gen_reg;
    logic [63:0] gen_next;

    assign gen_next = gen_reg + 64'(res_reg.gdelta) + 64'(gen_extra);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= hmt_pkg::FSM_IDLE;
            start_reg     <= 1'b0;
            m_axis_tvalid <= 1'b0;
            gen_reg       <= '0;
        end
        else
        begin
            state_reg <= state_next;
            start_reg <= accept;
            if (commit)
            begin
                m_axis_tvalid <= 1'b1;
                gen_reg       <= gen_next;
            end
            else if (m_axis_tready)
                m_axis_tvalid <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg      <= hmt_pkg::opcode_t'(s_axis_tuser[1:0]);
            text_ok_reg <= s_axis_tuser[2];
            key_reg     <= s_axis_tdata[63:0];
            inc_reg     <= s_axis_tdata[127:64];
            seq_reg     <= s_axis_tdata[191:128];
            now_reg     <= time64[TW-1:0];
        end
        if ((state_reg == hmt_pkg::FSM_SCAN) && end_tok.valid)
            res_reg <= end_tok;
        if (commit)
            m_axis_tdata <= {5'd0,
                             hmt_pkg::CNT_W'(expc_n),
                             hmt_pkg::CNT_W'(alive_n),
                             gen_next,
                             changed,
                             status};
    end

endmodule
